/* src/i2crr_pkg.sv */
`default_nettype none
package i2crr_pkg;

	localparam int PHASE_W = 7;

	localparam logic [PHASE_W-1:0] PH_ADDR_W  = 7'd3;
	localparam logic [PHASE_W-1:0] PH_REG     = 7'd30;
	localparam logic [PHASE_W-1:0] PH_RESTART = 7'd57;
	localparam logic [PHASE_W-1:0] PH_ADDR_R  = 7'd60;
	localparam logic [PHASE_W-1:0] PH_READ    = 7'd87;
	localparam logic [PHASE_W-1:0] PH_STOP    = 7'd106;
	localparam logic [PHASE_W-1:0] PH_LAST    = 7'd108;

	localparam logic [6:0] DEVICE_ADDRESS_RESET   = 7'h15;
	localparam logic [7:0] REGISTER_ADDRESS_RESET = 8'h02;

	localparam logic CFG_DEVICE_ADDRESS   = 1'b0;
	localparam logic CFG_REGISTER_ADDRESS = 1'b1;

	typedef struct packed {
		logic scl;
		logic sda;
		logic ack_sample;
		logic data_sample;
		logic wslot_end;
		logic last;
	} phase_ctl_t;

endpackage
`default_nettype wire

/* src/i2crr_phase_dec.sv */
`default_nettype none
module i2crr_phase_dec
	import i2crr_pkg::*;
(
	input  wire logic [PHASE_W-1:0] phase,
	input  wire logic [6:0]         device_address,
	input  wire logic [7:0]         register_address,
	output phase_ctl_t              ctl
);

	logic [PHASE_W-1:0] wbase;
	logic [PHASE_W-1:0] wdiff;
	logic [7:0]         wbyte;
	logic [4:0]         o;
	logic [8:0]         prod;
	logic [2:0]         q;
	logic [4:0]         r;
	logic [PHASE_W-1:0] rdiff;
	logic [4:0]         ro;

	always_comb begin
		if (phase < PH_REG) begin
			wbase = PH_ADDR_W;
			wbyte = {device_address, 1'b0};
		end else if (phase < PH_RESTART) begin
			wbase = PH_REG;
			wbyte = register_address;
		end else begin
			wbase = PH_ADDR_R;
			wbyte = {device_address, 1'b1};
		end
		wdiff = phase - wbase;
		o     = wdiff[4:0];
		// Bit number within the byte is o / 3, taken as (o * 11) >> 5 for o below 24.
		prod  = {4'b0, o} * 9'd11;
		q     = prod[7:5];
		r     = o - ({2'b0, q} + {1'b0, q, 1'b0});
		rdiff = phase - PH_READ;
		ro    = rdiff[4:0];

		ctl = '{scl: 1'b1, sda: 1'b1, ack_sample: 1'b0, data_sample: 1'b0,
			wslot_end: 1'b0, last: 1'b0};

		if (phase < PH_ADDR_W) begin
			ctl.scl = (phase < 7'd2);
			ctl.sda = (phase == 7'd0);
		end else if (phase < PH_RESTART || (phase >= PH_ADDR_R && phase < PH_READ)) begin
			if (o < 5'd24) begin
				ctl.scl = (r == 5'd1);
				ctl.sda = wbyte[3'd7 - q];
			end else if (o == 5'd25) begin
				ctl.scl        = 1'b1;
				ctl.ack_sample = 1'b1;
			end else begin
				ctl.scl       = 1'b0;
				ctl.wslot_end = (o == 5'd26);
			end
		end else if (phase < PH_ADDR_R) begin
			ctl.scl = (phase < PH_RESTART + 7'd2);
			ctl.sda = (phase == PH_RESTART);
		end else if (phase < PH_STOP) begin
			if (ro < 5'd16) begin
				ctl.scl         = ~ro[0];
				ctl.data_sample = ~ro[0];
			end else begin
				ctl.scl = (ro == 5'd17);
			end
		end else if (phase < PH_LAST) begin
			ctl.scl = (phase != PH_STOP);
			ctl.sda = 1'b0;
		end else begin
			ctl.last = 1'b1;
		end
	end

endmodule
`default_nettype wire

/* src/i2c_register_read_master.sv */
// Bit-level I2C master that reads one register byte. Every input item is one bus phase tick:
// it carries a go flag and the SDA level sampled at the end of the tick, and produces exactly
// one output item with the SCL and SDA levels to drive for that phase plus status. A go while
// idle starts start, address+write, register byte, repeated start, address+read, one byte
// answered with NACK and stop, 109 ticks in all; a NACK on an address or register byte skips
// to stop and ends with ok low. The last item of a transaction is marked by m_tlast. One item
// is accepted per clock cycle unless m_tready stalls the output; each item passes the input
// register and then the output register; phase counter and shift register step per item.
// The user must write configuration only while idle; the block itself does not enforce this.
`default_nettype none
module i2c_register_read_master
	import i2crr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // go, sda_level, zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // scl_level, sda_drive, busy_res, ok, read_value, wake
	output logic             m_tlast    // done_res
);

	logic [6:0]         device_address_q;
	logic [7:0]         register_address_q;
	logic               valid_s1;
	logic               go_s1;
	logic               sda_s1;
	logic [PHASE_W-1:0] phase_q;
	logic [7:0]         shift_q;
	logic               nack_q;
	logic               active_q;
	logic               out_valid_q;
	logic [12:0]        out_data_q;
	logic               out_last_q;

	logic               advance;
	logic               act;
	logic               start;
	logic [PHASE_W-1:0] p;
	logic [7:0]         shift_cur;
	logic               nack_cur;
	phase_ctl_t         ctl;
	logic               nack_n;
	logic [7:0]         shift_n;
	logic [PHASE_W-1:0] phase_n;
	logic               okv;
	logic [7:0]         val;
	logic               wk;
	logic [12:0]        res_data;
	logic               res_last;

	i2crr_phase_dec u_dec (
		.phase            (p),
		.device_address   (device_address_q),
		.register_address (register_address_q),
		.ctl              (ctl)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		start     = !active_q && go_s1;
		act       = active_q || go_s1;
		p         = active_q ? phase_q : '0;
		shift_cur = start ? 8'd0 : shift_q;
		nack_cur  = start ? 1'b0 : nack_q;
		nack_n    = nack_cur | (ctl.ack_sample & sda_s1);
		shift_n   = ctl.data_sample ? {shift_cur[6:0], sda_s1} : shift_cur;
		if (ctl.last) begin
			phase_n = '0;
		end else if (ctl.wslot_end && nack_n) begin
			phase_n = PH_STOP;
		end else begin
			phase_n = p + 7'd1;
		end
		okv = act && ctl.last && !nack_cur;
		val = okv ? shift_cur : 8'd0;
		wk  = okv && (val != 8'd0);
		if (act) begin
			res_data = {wk, val, okv, 1'b1, ctl.sda, ctl.scl};
			res_last = ctl.last;
		end else begin
			res_data = {1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1};
			res_last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q   <= DEVICE_ADDRESS_RESET;
			register_address_q <= REGISTER_ADDRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS:   device_address_q   <= cfg_data[6:0];
				CFG_REGISTER_ADDRESS: register_address_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			go_s1  <= s_tdata[0];
			sda_s1 <= s_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			shift_q  <= '0;
			nack_q   <= 1'b0;
			active_q <= 1'b0;
		end else if (advance && act) begin
			phase_q  <= phase_n;
			shift_q  <= shift_n;
			nack_q   <= nack_n;
			active_q <= !ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res_data;
			out_last_q <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b0, out_data_q};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

/* src/i2crr_checker.sv */
`default_nettype none
module i2crr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast
);

	// The final stop phase still belongs to the transaction and releases both lines.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[2] && m_tdata[0] && m_tdata[1])
		else $error("done item without busy or with lines held low");

	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> m_tdata[3] && m_tlast && m_tdata[11:4] != 8'd0)
		else $error("wake without a successful nonzero read");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == 8'd0 && !m_tdata[12])
		else $error("read value or wake set without ok");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1] && !m_tlast && !m_tdata[3])
		else $error("idle item drives the bus or reports status");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output item changed");

endmodule

bind i2c_register_read_master i2crr_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

/* tb/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import i2crr_pkg::*;

	typedef struct packed {
		logic go;
		logic sda;
	} tick_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic       ok;
		logic [7:0] value;
		logic       wake;
	} bus_phase_t;

	localparam int MODE_CLEAN    = 0;
	localparam int MODE_NACK_AW  = 1;
	localparam int MODE_NACK_REG = 2;
	localparam int MODE_NACK_AR  = 3;
	localparam int MODE_RANDOM   = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_DEVICE_ADDRESS;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	i2c_register_read_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	tick_t      tick_q[$];
	bus_phase_t phase_outputs_q[$];
	int         mismatches = 0;
	int         ticks_taken = 0;
	logic       tick_taken = 1'b0;

	// Predicted master state and its copy of the configuration.
	logic [6:0] dev_addr = DEVICE_ADDRESS_RESET;
	logic [7:0] reg_addr = REGISTER_ADDRESS_RESET;
	logic [6:0] step = '0;
	logic [7:0] rx_byte = '0;
	logic       nacked = 1'b0;
	logic       running = 1'b0;

	// The long stretch without any idling on either side.
	wire calm = ticks_taken >= 700 && ticks_taken < 1000;

	task automatic advance_bus_phase(input logic go, input logic sda_in, output bus_phase_t r);
		logic [6:0] nxt;
		logic [6:0] base;
		logic [7:0] tx;
		int off;
		r = '{scl: 1'b1, sda: 1'b1, default: '0};
		if (!running && go) begin
			running = 1'b1;
			step = '0;
			rx_byte = '0;
			nacked = 1'b0;
		end
		if (running) begin
			nxt = step + 7'd1;
			r.busy = 1'b1;
			if (step < PH_ADDR_W) begin
				r.scl = step < 7'd2;
				r.sda = step == 7'd0;
			end else if (step < PH_RESTART || (step >= PH_ADDR_R && step < PH_READ)) begin
				if (step < PH_REG) begin
					base = PH_ADDR_W;
					tx = {dev_addr, 1'b0};
				end else if (step < PH_RESTART) begin
					base = PH_REG;
					tx = reg_addr;
				end else begin
					base = PH_ADDR_R;
					tx = {dev_addr, 1'b1};
				end
				off = int'(step) - int'(base);
				if (off < 24) begin
					r.scl = (off % 3) == 1;
					r.sda = tx[7 - off / 3];
				end else begin
					r.sda = 1'b1;
					r.scl = off == 25;
					if (off == 25 && sda_in)
						nacked = 1'b1;
					if (off == 26 && nacked)
						nxt = PH_STOP;
				end
			end else if (step < PH_ADDR_R) begin
				off = int'(step) - int'(PH_RESTART);
				r.scl = off < 2;
				r.sda = off == 0;
			end else if (step < PH_STOP) begin
				off = int'(step) - int'(PH_READ);
				r.sda = 1'b1;
				if (off < 16) begin
					r.scl = (off % 2) == 0;
					if (r.scl)
						rx_byte = {rx_byte[6:0], sda_in};
				end else begin
					r.scl = off == 17;
				end
			end else if (step < PH_LAST) begin
				r.scl = step != PH_STOP;
				r.sda = 1'b0;
			end else begin
				r.done = 1'b1;
				r.ok = !nacked;
				r.value = r.ok ? rx_byte : 8'd0;
				r.wake = r.ok && r.value != 8'd0;
				running = 1'b0;
				nxt = '0;
			end
			step = nxt;
		end
	endtask

	task automatic check_field(input string name, input int want, input int seen);
		if (want != seen) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
			mismatches++;
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		bus_phase_t predicted;
		bus_phase_t want;
		if (arst_n) begin
			tick_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				advance_bus_phase(s_tdata[0], s_tdata[1], predicted);
				phase_outputs_q.push_back(predicted);
				ticks_taken <= ticks_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				if (phase_outputs_q.size() == 0) begin
					$display("%0t ns: unexpected item, expected none, got tdata %h tlast %b",
						$time, m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = phase_outputs_q.pop_front();
					check_field("scl_level", want.scl, m_tdata[0]);
					check_field("sda_drive", want.sda, m_tdata[1]);
					check_field("busy_res", want.busy, m_tdata[2]);
					check_field("ok", want.ok, m_tdata[3]);
					check_field("read_value", want.value, m_tdata[11:4]);
					check_field("wake", want.wake, m_tdata[12]);
					check_field("tdata padding", 0, m_tdata[15:13]);
					check_field("done_res", want.done, m_tlast);
				end
			end
		end
	end

	always @(negedge clk) begin
		tick_t t;
		if (arst_n) begin
			if (!s_tvalid || tick_taken) begin
				if (tick_q.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
					t = tick_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, t.sda, t.go};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= calm || $urandom_range(99) >= 18;
		end
	end

	task automatic queue_idle(input int n);
		repeat (n)
			tick_q.push_back('{go: 1'b0, sda: 1'($urandom_range(1))});
	endtask

	// One transaction from go to the stop, with the slave answering per mode.
	task automatic queue_read(input int mode, input logic [7:0] data, input bit noisy);
		int p;
		bit nk;
		tick_t t;
		p = 0;
		nk = 0;
		forever begin
			t.go = (p == 0) ? 1'b1 : (noisy ? 1'($urandom_range(1)) : 1'b0);
			t.sda = 1'($urandom_range(1));
			if (p == 28 || p == 55 || p == 85) begin
				t.sda = (mode == MODE_NACK_AW && p == 28) || (mode == MODE_NACK_REG && p == 55)
					|| (mode == MODE_NACK_AR && p == 85)
					|| (mode == MODE_RANDOM && $urandom_range(3) == 0);
				if (t.sda)
					nk = 1;
			end
			if (p >= 87 && p < 103 && ((p - 87) % 2) == 0)
				t.sda = data[7 - (p - 87) / 2];
			tick_q.push_back(t);
			if (p == int'(PH_LAST))
				break;
			p = (nk && (p == 29 || p == 56 || p == 86)) ? int'(PH_STOP) : p + 1;
		end
	endtask

	task automatic write_cfg(input logic idx, input logic [7:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_DEVICE_ADDRESS)
			dev_addr = data[6:0];
		else
			reg_addr = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || s_tvalid || phase_outputs_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic int pick_mode();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return MODE_CLEAN;
		else if (r < 76)
			return MODE_NACK_AW;
		else if (r < 82)
			return MODE_NACK_REG;
		else if (r < 88)
			return MODE_NACK_AR;
		return MODE_RANDOM;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		logic [6:0] dev;
		logic [7:0] rg;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: idle ticks, clean reads of both extreme bytes, a NACK on every
		// written byte, and go pulses while a transaction is running.
		queue_idle(2);
		queue_read(MODE_CLEAN, 8'hFF, 0);
		queue_read(MODE_CLEAN, 8'h00, 1);
		queue_idle(1);
		queue_read(MODE_NACK_AW, 8'hA5, 0);
		queue_read(MODE_NACK_REG, 8'h5A, 1);
		queue_read(MODE_NACK_AR, 8'h81, 0);
		queue_idle(3);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin dev = 7'd0; rg = 8'd0; end
				1: begin dev = 7'h7F; rg = 8'hFF; end
				2: begin dev = 7'h55; rg = 8'hAA; end
				3: begin dev = 7'h2A; rg = 8'h55; end
				default: begin dev = 7'($urandom); rg = 8'($urandom); end
			endcase
			write_cfg(CFG_DEVICE_ADDRESS, {1'($urandom_range(1)), dev});
			write_cfg(CFG_REGISTER_ADDRESS, rg);
			repeat (3) begin
				queue_idle($urandom_range(0, 4));
				queue_read(pick_mode(), pick_byte(), 1'($urandom_range(1)));
			end
			queue_idle($urandom_range(0, 3));
			drain();
		end

		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("i2c_register_read_master verification clean");
		else
			$display("i2c_register_read_master verification failed");
		$finish;
	end

	initial begin
		#4ms;
		$display("i2c_register_read_master verification failed");
		$finish;
	end

endmodule

/* filelist.f */
src/i2crr_pkg.sv
src/i2crr_phase_dec.sv
src/i2c_register_read_master.sv
src/i2crr_checker.sv
tb/testbench.sv
